FILE: design/scld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types, constants and the command table for the serial command line
// decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  localparam int unsigned WinDepth  = 7;
  localparam int unsigned DecBytes  = 6;
  localparam int unsigned FillW     = 3;
  localparam int unsigned ValueW    = 14;

  localparam logic [7:0] CHR_ESC   = 8'h1b;
  localparam logic [7:0] CHR_TILDE = 8'h7e;
  localparam logic [7:0] CHR_DEL   = 8'h7f;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;

  typedef logic [7:0] byte_t;
  typedef byte_t      win_t [WinDepth];
  typedef byte_t      dec_win_t [DecBytes];

  typedef enum logic [4:0] {
    CMD_CP, CMD_CI, CMD_CD, CMD_CA,
    CMD_MP, CMD_MI, CMD_MD,
    CMD_VO, CMD_VM, CMD_VS, CMD_VT, CMD_VB, CMD_VP,
    CMD_LP, CMD_LM, CMD_LC, CMD_LK, CMD_LS,
    CMD_SP, CMD_GP,
    CMD_UNKNOWN
  } cmd_id_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNKNOWN   = 2'd1,
    STAT_DIGIT_ERR = 2'd2
  } status_t;

  typedef struct packed {
    byte_t              first_letter;
    byte_t              second_letter;
    logic [ValueW-1:0]  value;
    cmd_id_t            command_id;
    status_t            status;
  } dec_res_t;

  function automatic cmd_id_t lookup_cmd(input byte_t a, input byte_t b);
    cmd_id_t id;
    case ({a, b})
      "cp":    id = CMD_CP;
      "ci":    id = CMD_CI;
      "cd":    id = CMD_CD;
      "ca":    id = CMD_CA;
      "mp":    id = CMD_MP;
      "mi":    id = CMD_MI;
      "md":    id = CMD_MD;
      "vo":    id = CMD_VO;
      "vm":    id = CMD_VM;
      "vs":    id = CMD_VS;
      "vt":    id = CMD_VT;
      "vb":    id = CMD_VB;
      "vp":    id = CMD_VP;
      "lp":    id = CMD_LP;
      "lm":    id = CMD_LM;
      "lc":    id = CMD_LC;
      "lk":    id = CMD_LK;
      "ls":    id = CMD_LS;
      "sp":    id = CMD_SP;
      "gp":    id = CMD_GP;
      default: id = CMD_UNKNOWN;
    endcase
    return id;
  endfunction

endpackage

FILE: design/scld_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_decode
// Decodes a captured line: two command letters, a four-digit decimal value
// and the command lookup with digit checking.
// ----------------------------------------------------------------------------
module scld_decode
  import scld_pkg::*;
(
  input  dec_win_t line,
  output dec_res_t res
);

  logic [3:0]        dig [4];
  logic [3:0]        digit_ok;
  logic [ValueW-1:0] val;
  cmd_id_t           id;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      digit_ok[i] = (line[i+2] >= CHR_ZERO) && (line[i+2] <= CHR_NINE);
      // '0'..'9' carry the digit in the low nibble
      dig[i]      = line[i+2][3:0];
    end
  end

  assign val = ValueW'(dig[0]) * ValueW'(1000) + ValueW'(dig[1]) * ValueW'(100)
             + ValueW'(dig[2]) * ValueW'(10) + ValueW'(dig[3]);

  assign id = lookup_cmd(line[0], line[1]);

  always_comb begin
    res.first_letter  = line[0];
    res.second_letter = line[1];
    if (&digit_ok) begin
      res.value      = val;
      res.command_id = id;
      res.status     = (id == CMD_UNKNOWN) ? STAT_UNKNOWN : STAT_OK;
    end else begin
      res.value      = '0;
      res.command_id = CMD_UNKNOWN;
      res.status     = STAT_DIGIT_ERR;
    end
  end

endmodule

FILE: design/serial_command_line_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Collects received bytes into a seven-byte line window and decodes a
// command and decimal value on each CR or LF.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                      | moves
//  in      | sink      | in_valid, in_stall, in_rx_byte             | one byte
//  out     | source    | out_valid, out_stall, out_first_letter,    | one decoded
//          |           | out_second_letter, out_value,              | line
//          |           | out_command_id, out_status                 |
//
//  One byte per cycle while in_stall is low. The window updates at the
//  accepting edge; a line end copies bytes 0..5 into the line register,
//  which is decoded into the output register when that register can load.
//  Synchronous active-low reset clears the window, fill count and valids.
//  in_stall rises only while the line register is full and the output
//  register is held by out_stall.
// ----------------------------------------------------------------------------
module serial_command_line_decoder
  import scld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_first_letter,
  output logic [7:0]  out_second_letter,
  output logic [13:0] out_value,
  output logic [4:0]  out_command_id,
  output logic [1:0]  out_status
);

  win_t             win_r, win_nxt, win_base;
  logic [FillW-1:0] fill_r, fill_nxt, fill_base;
  dec_win_t         line_r;
  logic             line_valid_r;
  dec_res_t         res, res_r;
  logic             out_valid_r;
  logic             in_acc, out_load, is_ctrl, is_eol;

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = line_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  assign is_ctrl = (in_rx_byte == CHR_ESC) || (in_rx_byte == CHR_TILDE)
                || (in_rx_byte == CHR_DEL);
  assign is_eol  = (in_rx_byte == CHR_CR) || (in_rx_byte == CHR_LF);

  // full window drops its oldest byte first; top byte keeps its value
  always_comb begin
    if (fill_r == FillW'(WinDepth)) begin
      for (int i = 0; i < WinDepth - 1; i++) win_base[i] = win_r[i+1];
      win_base[WinDepth-1] = win_r[WinDepth-1];
      fill_base = FillW'(WinDepth - 1);
    end else begin
      win_base  = win_r;
      fill_base = fill_r;
    end
  end

  always_comb begin
    win_nxt  = win_base;
    fill_nxt = fill_base;
    if (is_ctrl) begin
      fill_nxt = '0;
    end else begin
      for (int i = 0; i < WinDepth; i++) begin
        if (fill_base == FillW'(i)) win_nxt[i] = in_rx_byte;
      end
      fill_nxt = is_eol ? '0 : fill_base + FillW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WinDepth; i++) win_r[i] <= '0;
      fill_r <= '0;
    end else if (in_acc) begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
    end
  end

  // line register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_valid_r <= 1'b0;
    end else if (in_acc && !is_ctrl && is_eol) begin
      line_valid_r <= 1'b1;
    end else if (out_load) begin
      line_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_ctrl && is_eol) begin
      for (int i = 0; i < DecBytes; i++) line_r[i] <= win_nxt[i];
    end
  end

  scld_decode u_decode (
    .line (line_r),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= line_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && line_valid_r) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_first_letter  = res_r.first_letter;
  assign out_second_letter = res_r.second_letter;
  assign out_value         = res_r.value;
  assign out_command_id    = res_r.command_id;
  assign out_status        = res_r.status;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> line_valid_r && out_valid_r)
    else $error("input stalled without a pending line");

  a_eol_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_eol) |=> fill_r == '0 && line_valid_r)
    else $error("line end did not clear fill count or capture line");

  a_ctrl_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_ctrl) |=> fill_r == '0)
    else $error("control byte did not clear fill count");

  a_digit_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_DIGIT_ERR) |->
      out_value == '0 && out_command_id == CMD_UNKNOWN)
    else $error("digit error with non-zero value or known command");

  a_status_matches_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_DIGIT_ERR) |->
      ((out_status == STAT_UNKNOWN) == (out_command_id == CMD_UNKNOWN)))
    else $error("status disagrees with command id");

endmodule
